>>> rtl/core/sps_pkg.sv
// Shared types, constants and lookup functions for the servo pulse slew limiter.
`default_nettype none
package sps_pkg;

  localparam int NUM_CHANNELS     = 12;
  localparam int CH_W             = 4;
  localparam int PULSE_W          = 16;
  localparam int ANGLE_W          = 8;
  localparam int DIV_W            = 8;
  localparam int MASK_W           = 12;
  localparam int TICK_W           = 16;
  localparam int TICK_BIT_W       = 4;
  localparam int PULSE_PER_DEGREE = 38;

  localparam logic [MASK_W-1:0] MASK_RESET    = 12'd2934;
  localparam logic [DIV_W-1:0]  DIVISOR_RESET = 8'd2;
  localparam logic [CH_W-1:0]   LAST_CHANNEL  = CH_W'(NUM_CHANNELS - 1);
  localparam logic              MODE_SET      = 1'b1;

  // Feedback angle: |d| / 38 by reciprocal multiply, exact for |d| below the saturation limit.
  localparam int MAG_W       = 13;
  localparam int SAT_LIMIT   = 128 * PULSE_PER_DEGREE;
  localparam int RECIP_SHIFT = 18;
  localparam int RECIP       = (2 ** RECIP_SHIFT + PULSE_PER_DEGREE - 1) / PULSE_PER_DEGREE;
  localparam int QMAG_W      = 7;

  localparam int CMD_DEPTH = 4;
  localparam int RES_DEPTH = 4;
  localparam int QPTR_W    = 2;
  localparam int QCNT_W    = 3;

  typedef enum logic {
    CMD_TICK,
    CMD_SET
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [CH_W-1:0]      channel;
    logic [PULSE_W-1:0]   target;
    logic [DIV_W-1:0]     divisor;
  } cmd_t;

  typedef struct packed {
    logic [CH_W-1:0]           servo_index;
    logic [PULSE_W-1:0]        pulse;
    logic signed [ANGLE_W-1:0] angle_now;
    logic                      at_target;
    logic                      last;
  } res_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_WALK
  } back_state_t;

  function automatic logic [PULSE_W-1:0] rest_offset(input logic [CH_W-1:0] c);
    logic [PULSE_W-1:0] r;
    case (c)
      4'd0:    r = 16'd2846;
      4'd1:    r = 16'd3150;
      4'd2:    r = 16'd3644;
      4'd3:    r = 16'd7330;
      4'd4:    r = 16'd6950;
      4'd5:    r = 16'd6190;
      4'd6:    r = 16'd7178;
      4'd7:    r = 16'd6950;
      4'd8:    r = 16'd6532;
      4'd9:    r = 16'd2846;
      4'd10:   r = 16'd3150;
      4'd11:   r = 16'd3682;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  function automatic logic subtracts(input logic [CH_W-1:0] c, input logic [MASK_W-1:0] mask);
    logic r;
    r = 1'b0;
    if (32'(c) < MASK_W) r = mask[c];
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/sps_front.sv
// Front end: accepts input words, drops stray sets and turns angles into target pulses.
`default_nettype none
module sps_front import sps_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic                      mode,
  input  logic [CH_W-1:0]           channel,
  input  logic signed [ANGLE_W-1:0] angle,
  input  logic [DIV_W-1:0]          divisor,
  input  logic [MASK_W-1:0]         mask,
  input  logic                      q_full,
  output logic                      cmd_valid,
  output cmd_t                      cmd
);

  logic               accept;
  logic               keep;
  logic signed [13:0] ang_scaled;
  logic signed [17:0] base;
  logic signed [17:0] delta;
  logic signed [17:0] t_raw;
  logic [PULSE_W-1:0] t_sat;

  assign full   = cmd_valid && q_full;
  assign accept = push && !full;
  assign keep   = (mode != MODE_SET) || ({1'b0, channel} < (CH_W+1)'(NUM_CHANNELS));

  always_comb begin
    ang_scaled = $signed({{6{angle[ANGLE_W-1]}}, angle}) * 14'sd38;
    base       = $signed({2'b00, rest_offset(channel)});
    delta      = $signed({{4{ang_scaled[13]}}, ang_scaled});
    if (subtracts(channel, mask)) begin
      t_raw = base - delta;
    end else begin
      t_raw = base + delta;
    end
    if (t_raw < 18'sd0) begin
      t_sat = '0;
    end else if (t_raw > 18'sd65535) begin
      t_sat = '1;
    end else begin
      t_sat = t_raw[PULSE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (accept) begin
      cmd_valid <= keep;
    end else if (!q_full) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd.kind    <= (mode == MODE_SET) ? CMD_SET : CMD_TICK;
      cmd.channel <= channel;
      cmd.target  <= t_sat;
      cmd.divisor <= divisor;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/sps_cmd_queue.sv
// Short command queue between the front end and the channel walker.
`default_nettype none
module sps_cmd_queue import sps_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_word,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  cmd_t              mem [CMD_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == QCNT_W'(CMD_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_word;
  end

endmodule
`default_nettype wire

>>> rtl/core/sps_back.sv
// Back end: applies set commands and walks all channels once per tick.
`default_nettype none
module sps_back import sps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [MASK_W-1:0] mask,
  input  logic              cmd_valid,
  input  cmd_t              cmd,
  output logic              cmd_pop,
  input  logic [QCNT_W-1:0] res_count,
  output logic              res_push,
  output res_t              res_word
);

  back_state_t state, state_next;

  logic [TICK_W-1:0]  tick_count;
  logic               wrapped;
  logic [PULSE_W-1:0] target_pulse  [NUM_CHANNELS];
  logic [PULSE_W-1:0] current_pulse [NUM_CHANNELS];
  logic [DIV_W-1:0]   step_divisor  [NUM_CHANNELS];
  // Each channel keeps tick_count modulo its divisor so no division is needed per tick.
  logic [DIV_W-1:0]   step_phase    [NUM_CHANNELS];

  cmd_t                set_cmd;
  logic [CH_W-1:0]     idx;
  logic [TICK_BIT_W-1:0] bit_cnt;
  logic [DIV_W:0]      div_rem;
  logic [DIV_W:0]      div_shift;
  logic [DIV_W:0]      div_trial;

  logic               credit_ok;
  logic [QCNT_W-1:0]  committed;
  logic               div_step;
  logic               issue;

  logic [PULSE_W-1:0] cur;
  logic [PULSE_W-1:0] tgt;
  logic [DIV_W-1:0]   k;
  logic [DIV_W:0]     ph_inc;
  logic [DIV_W-1:0]   phase_new;
  logic               step;
  logic [PULSE_W-1:0] cur_new;

  logic               s1_valid;
  logic [CH_W-1:0]    s1_index;
  logic [PULSE_W-1:0] s1_pulse;
  logic               s1_at;
  logic               s1_last;
  logic               s1_sub;

  logic [PULSE_W:0]   diff;
  logic [PULSE_W:0]   mag;

  logic               s2_valid;
  logic [CH_W-1:0]    s2_index;
  logic [PULSE_W-1:0] s2_pulse;
  logic               s2_at;
  logic               s2_last;
  logic               s2_neg;
  logic               s2_sat;
  logic [MAG_W-1:0]   s2_mag;

  logic [2*MAG_W-1:0] prod;
  logic [QMAG_W-1:0]  qmag;
  logic signed [ANGLE_W-1:0] ang;

  // Results in flight count against the result queue so the walker never overruns it.
  assign committed = res_count + QCNT_W'(s1_valid) + QCNT_W'(s2_valid);
  assign credit_ok = (committed < QCNT_W'(RES_DEPTH));

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (cmd_valid) state_next = (cmd.kind == CMD_SET) ? BK_DIVIDE : BK_WALK;
      end
      BK_DIVIDE: begin
        if (bit_cnt == '0) state_next = BK_IDLE;
      end
      BK_WALK: begin
        if (credit_ok && (idx == LAST_CHANNEL)) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop  = 1'b0;
    div_step = 1'b0;
    issue    = 1'b0;
    case (state)
      BK_IDLE:   cmd_pop  = cmd_valid;
      BK_DIVIDE: div_step = 1'b1;
      BK_WALK:   issue    = credit_ok;
      default: begin
        cmd_pop  = 1'b0;
        div_step = 1'b0;
        issue    = 1'b0;
      end
    endcase
  end

  // Restoring remainder of tick_count by the new divisor, one bit per cycle.
  always_comb begin
    div_shift = {div_rem[DIV_W-1:0], tick_count[bit_cnt]};
    if (div_shift >= {1'b0, set_cmd.divisor}) begin
      div_trial = div_shift - {1'b0, set_cmd.divisor};
    end else begin
      div_trial = div_shift;
    end
  end

  always_comb begin
    cur    = current_pulse[idx];
    tgt    = target_pulse[idx];
    k      = step_divisor[idx];
    ph_inc = {1'b0, step_phase[idx]} + 1'b1;
    if (wrapped || (ph_inc == {1'b0, k})) begin
      phase_new = '0;
    end else begin
      phase_new = ph_inc[DIV_W-1:0];
    end
    step    = (k != '0) && (phase_new == '0);
    cur_new = cur;
    if (step) begin
      if (cur < tgt) begin
        cur_new = cur + 1'b1;
      end else if (cur > tgt) begin
        cur_new = cur - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      tick_count <= '0;
      wrapped    <= 1'b0;
      idx        <= '0;
      bit_cnt    <= '0;
      div_rem    <= '0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        target_pulse[c]  <= rest_offset(CH_W'(c));
        current_pulse[c] <= rest_offset(CH_W'(c));
        step_divisor[c]  <= DIVISOR_RESET;
        step_phase[c]    <= '0;
      end
    end else begin
      state    <= state_next;
      s1_valid <= issue;
      s2_valid <= s1_valid;
      if (cmd_pop) begin
        idx     <= '0;
        bit_cnt <= '1;
        div_rem <= '0;
        if (cmd.kind == CMD_TICK) begin
          tick_count <= tick_count + 1'b1;
          wrapped    <= (tick_count == '1);
        end
      end
      if (div_step) begin
        div_rem <= div_trial;
        bit_cnt <= bit_cnt - 1'b1;
        if (bit_cnt == '0) begin
          target_pulse[set_cmd.channel] <= set_cmd.target;
          step_divisor[set_cmd.channel] <= set_cmd.divisor;
          step_phase[set_cmd.channel]   <= div_trial[DIV_W-1:0];
        end
      end
      if (issue) begin
        current_pulse[idx] <= cur_new;
        step_phase[idx]    <= phase_new;
        idx                <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) set_cmd <= cmd;
  end

  always_comb begin
    diff = {1'b0, s1_pulse} - {1'b0, rest_offset(s1_index)};
    mag  = diff[PULSE_W] ? (~diff + 1'b1) : diff;
  end

  always_ff @(posedge clk) begin
    s1_index <= idx;
    s1_pulse <= cur_new;
    s1_at    <= (cur_new == tgt);
    s1_last  <= (idx == LAST_CHANNEL);
    s1_sub   <= subtracts(idx, mask);

    s2_index <= s1_index;
    s2_pulse <= s1_pulse;
    s2_at    <= s1_at;
    s2_last  <= s1_last;
    s2_neg   <= diff[PULSE_W] ^ s1_sub;
    s2_sat   <= (mag >= (PULSE_W+1)'(SAT_LIMIT));
    s2_mag   <= mag[MAG_W-1:0];
  end

  always_comb begin
    prod = (2*MAG_W)'(s2_mag) * (2*MAG_W)'(RECIP);
    qmag = prod[RECIP_SHIFT +: QMAG_W];
    if (s2_sat) begin
      ang = s2_neg ? -8'sd128 : 8'sd127;
    end else if (s2_neg) begin
      ang = $signed(-{1'b0, qmag});
    end else begin
      ang = $signed({1'b0, qmag});
    end
  end

  assign res_push             = s2_valid;
  assign res_word.servo_index = s2_index;
  assign res_word.pulse       = s2_pulse;
  assign res_word.angle_now   = ang;
  assign res_word.at_target   = s2_at;
  assign res_word.last        = s2_last;

endmodule
`default_nettype wire

>>> rtl/core/sps_res_queue.sv
// Result queue that holds finished channel words until they are popped.
`default_nettype none
module sps_res_queue import sps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  res_t              push_word,
  output logic [QCNT_W-1:0] count,
  input  logic              pop,
  output logic              empty,
  output res_t              head
);

  res_t              mem [RES_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic              do_push;
  logic              do_pop;

  assign empty   = (count == '0);
  assign do_push = push && (count != QCNT_W'(RES_DEPTH));
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_word;
  end

endmodule
`default_nettype wire

>>> rtl/core/servo_pulse_slew_limiter_unit.sv
// Top level of the twelve-channel servo pulse slew limiter.
// A set word stores one channel's target pulse and step divisor; a tick word advances the
// tick count and produces twelve result words, channel 0 first, with last marking channel 11.
// The back end walks one channel per cycle while the result queue has room, and the
// two-stage feedback pipeline (s1, s2) carries each word into the result queue. A set
// rebuilds the channel's tick phase by a 16-step bit-serial remainder of the tick count.
// Set words naming a channel of 12 or above are accepted and discarded. A four-entry
// command queue lets new words be taken while the walker is busy, and a four-entry result
// queue holds words until popped; the walker pauses whenever the result queue has no room.
// The direction mask is written through cfg_we and cfg_wdata; the user must write it
// only while the block is idle, and the block itself does not enforce this.
`default_nettype none
module servo_pulse_slew_limiter_unit import sps_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [MASK_W-1:0]         cfg_wdata,
  input  logic                      push,
  output logic                      full,
  input  logic                      mode,
  input  logic [CH_W-1:0]           channel,
  input  logic signed [ANGLE_W-1:0] angle,
  input  logic [DIV_W-1:0]          divisor,
  output logic                      empty,
  input  logic                      pop,
  output logic [CH_W-1:0]           servo_index,
  output logic [PULSE_W-1:0]        pulse,
  output logic signed [ANGLE_W-1:0] angle_now,
  output logic                      at_target,
  output logic                      last
);

  logic [MASK_W-1:0] direction_mask;
  logic              front_valid;
  cmd_t              front_cmd;
  logic              cmdq_full;
  logic              cmdq_empty;
  cmd_t              cmdq_head;
  logic              cmd_pop;
  logic              res_push;
  res_t              res_word;
  logic [QCNT_W-1:0] res_count;
  res_t              res_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction_mask <= MASK_RESET;
    end else if (cfg_we) begin
      direction_mask <= cfg_wdata;
    end
  end

  sps_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .mode      (mode),
    .channel   (channel),
    .angle     (angle),
    .divisor   (divisor),
    .mask      (direction_mask),
    .q_full    (cmdq_full),
    .cmd_valid (front_valid),
    .cmd       (front_cmd)
  );

  sps_cmd_queue u_cmdq (
    .clk       (clk),
    .rst       (rst),
    .push      (front_valid),
    .push_word (front_cmd),
    .full      (cmdq_full),
    .pop       (cmd_pop),
    .empty     (cmdq_empty),
    .head      (cmdq_head)
  );

  sps_back u_back (
    .clk       (clk),
    .rst       (rst),
    .mask      (direction_mask),
    .cmd_valid (!cmdq_empty),
    .cmd       (cmdq_head),
    .cmd_pop   (cmd_pop),
    .res_count (res_count),
    .res_push  (res_push),
    .res_word  (res_word)
  );

  sps_res_queue u_resq (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_word (res_word),
    .count     (res_count),
    .pop       (pop),
    .empty     (empty),
    .head      (res_head)
  );

  assign servo_index = res_head.servo_index;
  assign pulse       = res_head.pulse;
  assign angle_now   = res_head.angle_now;
  assign at_target   = res_head.at_target;
  assign last        = res_head.last;

endmodule
`default_nettype wire

>>> rtl/core/sps_checker.sv
// Port-level checks on the result stream and input full flag of the slew limiter, bound to the top level.
`default_nettype none
module sps_checker import sps_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      full,
  input logic                      empty,
  input logic                      pop,
  input logic [CH_W-1:0]           servo_index,
  input logic                      last
);

  // Nothing is waiting right after reset.
  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (servo_index <= LAST_CHANNEL))
    else $error("servo_index out of range");

  a_last_on_final: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (last == (servo_index == LAST_CHANNEL)))
    else $error("last mark does not match the final channel");

  // Words of one tick come out in channel order.
  a_index_order: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty) ##1 !empty |->
      (servo_index == ($past(last) ? '0 : $past(servo_index) + 1'b1)))
    else $error("result words out of channel order");

  a_full_after_reset: assert property (@(posedge clk) rst |=> !full)
    else $error("input reports full after reset");

endmodule

bind servo_pulse_slew_limiter_unit sps_checker u_sps_checker (
  .clk         (clk),
  .rst         (rst),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .servo_index (servo_index),
  .last        (last)
);
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the servo pulse slew limiter top level.
`timescale 1ns / 100ps
module testbench;
  import sps_pkg::*;

  localparam logic MODE_TICK = 1'b0;
  localparam int DEGREE_COUNTS = 38;
  localparam int DRAIN_LATENCY = 120;
  localparam int LONG_HOLD = 300;
  localparam logic [15:0] REST_PULSE [12] = '{
    16'd2846, 16'd3150, 16'd3644, 16'd7330, 16'd6950, 16'd6190,
    16'd7178, 16'd6950, 16'd6532, 16'd2846, 16'd3150, 16'd3682
  };

  typedef enum int {
    DRAIN_ALL,
    DRAIN_HALF,
    DRAIN_SPARSE,
    DRAIN_EVERY_THIRD
  } drain_pattern_t;

  // Tracks every channel's pulse and target and queues the words a tick will report.
  class servo_pulse_tracker;
    logic [11:0] dir_mask;
    logic [15:0] tick_count;
    logic [15:0] target_pulse [12];
    logic [15:0] current_pulse [12];
    logic [7:0]  step_div [12];
    res_t        pending_reports [$];
    int          errors;

    function new();
      dir_mask = MASK_RESET;
      tick_count = '0;
      errors = 0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        target_pulse[c] = REST_PULSE[c];
        current_pulse[c] = REST_PULSE[c];
        step_div[c] = 8'd2;
      end
    endfunction

    function int pending();
      return pending_reports.size();
    endfunction

    function void accept_word(logic m, logic [3:0] ch, logic signed [7:0] ang,
                              logic [7:0] div);
      int aim;
      int d;
      int q;
      res_t r;
      if (m == MODE_SET) begin
        if (ch >= NUM_CHANNELS) return;
        if (dir_mask[ch]) aim = int'(REST_PULSE[ch]) - int'(ang) * DEGREE_COUNTS;
        else aim = int'(REST_PULSE[ch]) + int'(ang) * DEGREE_COUNTS;
        if (aim < 0) aim = 0;
        if (aim > 65535) aim = 65535;
        target_pulse[ch] = 16'(aim);
        step_div[ch] = div;
        return;
      end
      tick_count = tick_count + 16'd1;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        if (step_div[c] != 0 && (tick_count % step_div[c]) == 0) begin
          if (current_pulse[c] < target_pulse[c]) current_pulse[c]++;
          else if (current_pulse[c] > target_pulse[c]) current_pulse[c]--;
        end
        // Signed division truncates toward zero, as the feedback requires.
        d = int'(current_pulse[c]) - int'(REST_PULSE[c]);
        q = d / DEGREE_COUNTS;
        if (dir_mask[c]) q = -q;
        if (q > 127) q = 127;
        if (q < -128) q = -128;
        r.servo_index = 4'(c);
        r.pulse = current_pulse[c];
        r.angle_now = 8'(q);
        r.at_target = (current_pulse[c] == target_pulse[c]);
        r.last = (c == NUM_CHANNELS - 1);
        pending_reports.push_back(r);
      end
    endfunction

    function void mismatch(string field, logic signed [16:0] want, logic signed [16:0] got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    endfunction

    function void check_report(res_t got);
      res_t want;
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected word, channel %0d pulse %0d", $time,
                 got.servo_index, got.pulse);
        errors++;
        return;
      end
      want = pending_reports.pop_front();
      if (got.servo_index !== want.servo_index)
        mismatch("servo_index", 17'(want.servo_index), 17'(got.servo_index));
      if (got.pulse !== want.pulse)
        mismatch("pulse", 17'(want.pulse), 17'(got.pulse));
      if (got.angle_now !== want.angle_now)
        mismatch("angle_now", 17'(want.angle_now), 17'(got.angle_now));
      if (got.at_target !== want.at_target)
        mismatch("at_target", 17'(want.at_target), 17'(got.at_target));
      if (got.last !== want.last)
        mismatch("last", 17'(want.last), 17'(got.last));
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [MASK_W-1:0]         cfg_wdata;
  logic                      push;
  logic                      full;
  logic                      mode;
  logic [CH_W-1:0]           channel;
  logic signed [ANGLE_W-1:0] angle;
  logic [DIV_W-1:0]          divisor;
  logic                      empty;
  logic                      pop;
  logic [CH_W-1:0]           servo_index;
  logic [PULSE_W-1:0]        pulse;
  logic signed [ANGLE_W-1:0] angle_now;
  logic                      at_target;
  logic                      last;

  servo_pulse_tracker tracker;
  res_t               seen_word;
  bit                 hold_request;
  int                 burst_left;

  servo_pulse_slew_limiter_unit uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .push        (push),
    .full        (full),
    .mode        (mode),
    .channel     (channel),
    .angle       (angle),
    .divisor     (divisor),
    .empty       (empty),
    .pop         (pop),
    .servo_index (servo_index),
    .pulse       (pulse),
    .angle_now   (angle_now),
    .at_target   (at_target),
    .last        (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      seen_word.servo_index = servo_index;
      seen_word.pulse = pulse;
      seen_word.angle_now = angle_now;
      seen_word.at_target = at_target;
      seen_word.last = last;
      tracker.check_report(seen_word);
    end
  end

  // Receiver: switches among drain patterns, and honors one long hold on request.
  initial begin
    drain_pattern_t pattern;
    int pattern_left;
    int stall_left;
    int phase;
    pop = 1'b0;
    pattern = DRAIN_ALL;
    pattern_left = 0;
    stall_left = 0;
    phase = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          pattern = drain_pattern_t'($urandom_range(0, 3));
          pattern_left = $urandom_range(10, 80);
        end
        pattern_left--;
        phase++;
        case (pattern)
          DRAIN_ALL: pop <= 1'b1;
          DRAIN_HALF: pop <= 1'($urandom);
          DRAIN_SPARSE: pop <= ($urandom_range(0, 7) == 0);
          default: pop <= (phase % 3 == 0);
        endcase
      end
    end
  end

  task automatic send_word(logic m, logic [3:0] ch, logic [7:0] ang, logic [7:0] div);
    @(negedge clk);
    push <= 1'b1;
    mode <= m;
    channel <= ch;
    angle <= ang;
    divisor <= div;
    @(posedge clk);
    while (full) @(posedge clk);
    tracker.accept_word(m, ch, ang, div);
  endtask

  task automatic idle_sender(int n);
    repeat (n) begin
      @(negedge clk);
      push <= 1'b0;
    end
  endtask

  // Sender bursts: a random run of back-to-back words, then sometimes a gap.
  task automatic pace();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 8));
    end else begin
      burst_left--;
    end
  endtask

  task automatic paced_word(logic m, logic [3:0] ch, logic [7:0] ang, logic [7:0] div);
    pace();
    send_word(m, ch, ang, div);
  endtask

  // Set words leave no result behind, so allow the command queue to drain after the last tick.
  task automatic wait_drained();
    idle_sender(1);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_LATENCY) @(posedge clk);
  endtask

  task automatic write_mask(logic [11:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    tracker.dir_mask = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random_phase(int quota);
    int counted;
    int a;
    logic [3:0] ch;
    logic m;
    counted = 0;
    while (counted < quota) begin
      if ($urandom_range(0, 9) < 7) begin
        // Retarget a few channels, mostly close to their rest pulse, then let them slew.
        repeat ($urandom_range(1, 3)) begin
          ch = 4'($urandom_range(0, NUM_CHANNELS - 1));
          a = int'($urandom_range(0, 6)) - 3;
          if ($urandom_range(0, 4) == 0) a = int'($urandom_range(0, 255)) - 128;
          paced_word(MODE_SET, ch, 8'(a), 8'($urandom_range(1, 3)));
          counted++;
        end
        repeat ($urandom_range(3, 12)) begin
          paced_word(MODE_TICK, 4'd0, 8'($urandom), 8'($urandom));
          counted++;
        end
      end else begin
        m = 1'($urandom);
        ch = 4'($urandom);
        paced_word(m, ch, 8'($urandom), 8'($urandom));
        if (m == MODE_TICK || ch < NUM_CHANNELS) counted++;
      end
    end
  endtask

  initial begin
    tracker = new();
    hold_request = 1'b0;
    burst_left = 0;
    rst = 1'b1;
    push = 1'b0;
    mode = MODE_TICK;
    channel = '0;
    angle = '0;
    divisor = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset state, saturated targets, zero divisor, ignored channels.
    paced_word(MODE_TICK, 4'd0, 8'd0, 8'd0);
    paced_word(MODE_TICK, 4'd0, 8'd0, 8'd0);
    paced_word(MODE_SET, 4'd0, 8'h80, 8'd1);
    paced_word(MODE_SET, 4'd3, 8'h7F, 8'd255);
    paced_word(MODE_SET, 4'd1, 8'h7F, 8'd0);
    paced_word(MODE_SET, 4'd2, 8'h80, 8'd1);
    paced_word(MODE_SET, 4'd15, 8'd5, 8'd3);
    paced_word(MODE_SET, 4'd12, 8'hFF, 8'd1);
    paced_word(MODE_SET, 4'd11, 8'd1, 8'd2);
    paced_word(MODE_SET, 4'd5, 8'd0, 8'd128);
    repeat (6) paced_word(MODE_TICK, 4'd15, 8'hFF, 8'hFF);
    paced_word(MODE_SET, 4'd0, 8'd0, 8'd1);
    repeat (3) paced_word(MODE_TICK, 4'd0, 8'd0, 8'd0);
    wait_drained();

    write_mask(12'h000);
    run_random_phase(15);
    wait_drained();

    // Hold the result side off while ticks keep coming, so both queues fill.
    write_mask(12'hFFF);
    hold_request = 1'b1;
    repeat (16) send_word(MODE_TICK, 4'd0, 8'd0, 8'd0);
    run_random_phase(15);
    wait_drained();

    write_mask(12'($urandom));
    run_random_phase(15);
    wait_drained();

    write_mask(12'hA5A);
    run_random_phase(15);
    wait_drained();

    if (tracker.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/sps_pkg.sv
rtl/core/sps_front.sv
rtl/core/sps_cmd_queue.sv
rtl/core/sps_back.sv
rtl/core/sps_res_queue.sv
rtl/core/servo_pulse_slew_limiter_unit.sv
rtl/core/sps_checker.sv
tb/testbench.sv
